// ===== src/frcb_pkg.sv =====
package frcb_pkg;

    localparam int OP_W    = 2;
    localparam int POS_W   = 9;
    localparam int BIN_W   = 9;
    localparam int DIM_W   = 10;
    localparam int SUM_W   = 36;
    localparam int CNT_W   = 19;
    localparam int TERM_W  = 18;
    localparam int R2_W    = 24;
    localparam int Q_W     = 35;
    localparam int ROOT_W  = 18;
    localparam int SQ_IN_W = 36;
    localparam int STEP_W  = 5;

    localparam logic [DIM_W-1:0]  DIM_RESET = 10'd512;
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]  SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [STEP_W-1:0] MAC_LAST  = 5'd16;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM      = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_RSQ_GO,
        S_RSQ_WAIT,
        S_RADJ,
        S_DIV_GO,
        S_DIV_WAIT,
        S_QSQ_GO,
        S_QSQ_WAIT,
        S_TERM,
        S_RD,
        S_WR
    } state_t;

    typedef enum logic [3:0] {
        ST_NONE,
        ST_R2,
        ST_G1,
        ST_G2,
        ST_PR,
        ST_PI,
        ST_CM,
        ST_CSQ,
        ST_P
    } store_t;

    // Handshake between the sequencer and an iterative unit.
    typedef struct packed {
        logic start;
        logic done;
    } unit_ctrl_t;

endpackage

// ===== src/frcb_req_if.sv =====
interface frcb_req_if #(
    parameter int SAMPLE_BITS = 24
);
    import frcb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               opcode;
    logic [POS_W-1:0]              row;
    logic [POS_W-1:0]              col;
    logic [BIN_W-1:0]              bin_index;
    logic signed [SAMPLE_BITS-1:0] first_real;
    logic signed [SAMPLE_BITS-1:0] first_imag;
    logic signed [SAMPLE_BITS-1:0] second_real;
    logic signed [SAMPLE_BITS-1:0] second_imag;

    modport source (
        output valid, opcode, row, col, bin_index,
        output first_real, first_imag, second_real, second_imag,
        input  ready
    );
    modport sink (
        input  valid, opcode, row, col, bin_index,
        input  first_real, first_imag, second_real, second_imag,
        output ready
    );
endinterface

// ===== src/frcb_rsp_if.sv =====
interface frcb_rsp_if;
    import frcb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BIN_W-1:0]        read_bin;
    logic signed [SUM_W-1:0] ring_sum;
    logic [CNT_W-1:0]        ring_count;

    modport source (
        output valid, read_bin, ring_sum, ring_count,
        input  ready
    );
    modport sink (
        input  valid, read_bin, ring_sum, ring_count,
        output ready
    );
endinterface

// ===== src/frcb_ram.sv =====
module frcb_ram #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/frcb_isqrt.sv =====
module frcb_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frcb_pkg::unit_ctrl_t           ctrl_in,
    output frcb_pkg::unit_ctrl_t           ctrl_out,
    input  logic [frcb_pkg::SQ_IN_W-1:0]   value,
    output logic [frcb_pkg::ROOT_W-1:0]    root
);
    import frcb_pkg::*;

    // One result bit per cycle, most significant first.
    logic [SQ_IN_W-1:0] val_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W-1:0]  bit_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [ROOT_W-1:0]  trial;
    logic [SQ_IN_W-1:0] trial_sq;

    assign trial    = root_reg | bit_reg;
    assign trial_sq = SQ_IN_W'(trial) * SQ_IN_W'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl_in.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.start)
        begin
            val_reg  <= value;
            root_reg <= '0;
            bit_reg  <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (trial_sq <= val_reg)
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
    end

    assign ctrl_out.start = busy_reg;
    assign ctrl_out.done  = done_reg;
    assign root           = root_reg;
endmodule

// ===== src/frcb_divider.sv =====
module frcb_divider #(
    parameter int W = 96
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  frcb_pkg::unit_ctrl_t       ctrl_in,
    output frcb_pkg::unit_ctrl_t       ctrl_out,
    input  logic [W-1:0]               num,
    input  logic [W-1:0]               den,
    output logic [frcb_pkg::Q_W-1:0]   quot
);
    import frcb_pkg::*;

    localparam int CW = $clog2(Q_W);

    // Computes floor(num * 2^(Q_W-1) / den) for num <= den, one quotient
    // bit per cycle. The first step compares without a shift.
    logic [W:0]     rem_reg;
    logic [W-1:0]   den_reg;
    logic [Q_W-1:0] q_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     shifted;
    logic           ge;

    assign shifted = (cnt_reg == '0) ? rem_reg : {rem_reg[W-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl_in.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == CW'(Q_W - 1)))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign ctrl_out.start = busy_reg;
    assign ctrl_out.done  = done_reg;
    assign quot           = q_reg;
endmodule

// ===== src/fourier_ring_correlation_binner_unit.sv =====
// Channel   Dir  Payload                                            Accepted when
// req       in   opcode, row, col, bin_index, four complex parts    req.valid & req.ready
// rsp       out  read_bin, ring_sum, ring_count                     rsp.valid & rsp.ready
// cfg       in   cfg_index, cfg_data                                cfg_we
//
// One request is worked on at a time. A read or read-and-clear request passes
// through the check, memory-read and write states to the result register, and
// the next request is taken once the block is back in idle. An accumulate
// request runs 17 steps of the shared multiplier, the integer square root for
// the ring index and, when both powers are nonzero, the restoring divider and
// the square root again for the correlation, plus memory access. Out-of-size
// accumulates are dropped after the check state. After reset a clearing pass
// writes zero to every bin, one per cycle; requests wait meanwhile, and
// configuration writes are taken. A stalled result holds in the output register;
// a read request waits only before its memory read.
module fourier_ring_correlation_binner_unit #(
    parameter int MAX_SIZE    = 512,
    parameter int NUM_BINS    = 512,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    frcb_req_if.sink                   req,
    frcb_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [frcb_pkg::DIM_W-1:0] cfg_data
);
    import frcb_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int MW    = (SB > 12) ? SB : 12;
    localparam int G_W   = 2 * SB;
    localparam int ACC_W = 4 * SB;
    localparam int AW    = $clog2(NUM_BINS);
    localparam int MEM_W = SUM_W + CNT_W;
    localparam int D_W   = DIM_W + 2;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [DIM_W-1:0] width_reg, height_reg;

    // Request held for the whole job.
    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] row_reg, col_reg;
    logic [BIN_W-1:0] bin_in_reg;
    logic [SB-1:0]    f1r_reg, f1i_reg, f2r_reg, f2i_reg;

    // Correlation datapath.
    logic [SB-1:0]       m1r_reg, m1i_reg, m2r_reg, m2i_reg;
    logic                n1r_reg, n1i_reg, n2r_reg, n2i_reg;
    logic [MW-1:0]       dxm_reg, dym_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [R2_W-1:0]     r2_reg;
    logic [G_W-1:0]      g1_reg, g2_reg, pr_reg, pi_reg, cmag_reg;
    logic                cneg_reg;
    logic [ACC_W-1:0]    csq_reg, p_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic [AW-1:0]       bin_reg;
    logic                bin_ok_reg;
    logic [AW:0]         clr_cnt_reg;

    // Result register.
    logic                    out_valid_reg;
    logic [BIN_W-1:0]        out_bin_reg;
    logic [SUM_W-1:0]        out_sum_reg;
    logic [CNT_W-1:0]        out_cnt_reg;

    // Check stage: size clipping, distance from the centre, sample magnitudes.
    logic [DIM_W-1:0]       w_eff, h_eff;
    logic signed [D_W-1:0]  dx_s, dy_s;
    logic [D_W-1:0]         dx_abs, dy_abs;
    logic                   in_range;

    assign w_eff = (32'(width_reg) > 32'(MAX_SIZE)) ? DIM_W'(MAX_SIZE) : width_reg;
    assign h_eff = (32'(height_reg) > 32'(MAX_SIZE)) ? DIM_W'(MAX_SIZE) : height_reg;
    assign dx_s  = $signed(D_W'(col_reg)) - $signed(D_W'(w_eff >> 1));
    assign dy_s  = $signed(D_W'(row_reg)) - $signed(D_W'(h_eff >> 1));
    assign dx_abs = dx_s[D_W-1] ? D_W'(-dx_s) : D_W'(dx_s);
    assign dy_abs = dy_s[D_W-1] ? D_W'(-dy_s) : D_W'(dy_s);
    assign in_range = (D_W'(row_reg) < D_W'(h_eff)) && (D_W'(col_reg) < D_W'(w_eff));

    // Two's complement negation of the most negative code gives its
    // magnitude correctly as an unsigned value.
    logic [SB-1:0] m1r, m1i, m2r, m2i;
    assign m1r = f1r_reg[SB-1] ? (~f1r_reg + SB'(1)) : f1r_reg;
    assign m1i = f1i_reg[SB-1] ? (~f1i_reg + SB'(1)) : f1i_reg;
    assign m2r = f2r_reg[SB-1] ? (~f2r_reg + SB'(1)) : f2r_reg;
    assign m2i = f2i_reg[SB-1] ? (~f2i_reg + SB'(1)) : f2i_reg;

    // Multiply sequencer: one multiplier, accumulated into a wide register
    // with a shift of 0, SB or 2*SB bits. The products of two 2*SB-bit values
    // (the squared cross term and the power product) take four steps each.
    logic [MW-1:0]    a_op, b_op;
    logic [1:0]       sh;
    logic             clr;
    store_t           store;
    logic [2*MW-1:0]  prod;
    logic [ACC_W-1:0] prod_ext, shifted, acc_sum;
    logic [MW-1:0]    c_lo, c_hi, g1_lo, g1_hi, g2_lo, g2_hi;

    assign c_lo  = MW'(cmag_reg[SB-1:0]);
    assign c_hi  = MW'(cmag_reg[G_W-1:SB]);
    assign g1_lo = MW'(g1_reg[SB-1:0]);
    assign g1_hi = MW'(g1_reg[G_W-1:SB]);
    assign g2_lo = MW'(g2_reg[SB-1:0]);
    assign g2_hi = MW'(g2_reg[G_W-1:SB]);

    always_comb
    begin
        a_op  = '0;
        b_op  = '0;
        sh    = 2'd0;
        clr   = 1'b0;
        store = ST_NONE;
        unique case (step_reg)
            5'd0:  begin a_op = dxm_reg;     b_op = dxm_reg;     clr = 1'b1; end
            5'd1:  begin a_op = dym_reg;     b_op = dym_reg;     store = ST_R2; end
            5'd2:  begin a_op = MW'(m1r_reg); b_op = MW'(m1r_reg); clr = 1'b1; end
            5'd3:  begin a_op = MW'(m1i_reg); b_op = MW'(m1i_reg); store = ST_G1; end
            5'd4:  begin a_op = MW'(m2r_reg); b_op = MW'(m2r_reg); clr = 1'b1; end
            5'd5:  begin a_op = MW'(m2i_reg); b_op = MW'(m2i_reg); store = ST_G2; end
            5'd6:  begin a_op = MW'(m1r_reg); b_op = MW'(m2r_reg); clr = 1'b1; store = ST_PR; end
            5'd7:  begin a_op = MW'(m1i_reg); b_op = MW'(m2i_reg); clr = 1'b1; store = ST_PI; end
            5'd8:  begin clr = 1'b1; store = ST_CM; end
            5'd9:  begin a_op = c_lo;  b_op = c_lo;  clr = 1'b1; end
            5'd10: begin a_op = c_lo;  b_op = c_hi;  sh = 2'd1; end
            5'd11: begin a_op = c_hi;  b_op = c_lo;  sh = 2'd1; end
            5'd12: begin a_op = c_hi;  b_op = c_hi;  sh = 2'd2; store = ST_CSQ; end
            5'd13: begin a_op = g1_lo; b_op = g2_lo; clr = 1'b1; end
            5'd14: begin a_op = g1_lo; b_op = g2_hi; sh = 2'd1; end
            5'd15: begin a_op = g1_hi; b_op = g2_lo; sh = 2'd1; end
            5'd16: begin a_op = g1_hi; b_op = g2_hi; sh = 2'd2; store = ST_P; end
            default: begin end
        endcase
    end

    assign prod     = (2*MW)'(a_op) * (2*MW)'(b_op);
    assign prod_ext = ACC_W'(prod);

    always_comb
    begin
        unique case (sh)
            2'd1:    shifted = prod_ext << SB;
            2'd2:    shifted = prod_ext << (2 * SB);
            default: shifted = prod_ext;
        endcase
    end

    assign acc_sum = (clr ? '0 : acc_reg) + shifted;

    // Cross term Re(F1 * conj(F2)) as sign and magnitude.
    logic           sr, si;
    logic [G_W-1:0] cm;
    logic           cm_neg;

    assign sr = n1r_reg ^ n2r_reg;
    assign si = n1i_reg ^ n2i_reg;

    always_comb
    begin
        priority if (sr == si)
        begin
            cm     = pr_reg + pi_reg;
            cm_neg = sr;
        end
        else if (pr_reg >= pi_reg)
        begin
            cm     = pr_reg - pi_reg;
            cm_neg = sr;
        end
        else
        begin
            cm     = pi_reg - pr_reg;
            cm_neg = si;
        end
    end

    // Iterative units.
    unit_ctrl_t           sq_in, sq_out, div_in, div_out;
    logic [SQ_IN_W-1:0]   sq_value;
    logic [ROOT_W-1:0]    sq_root;
    logic [Q_W-1:0]       quot;

    assign sq_value = (state_reg == S_QSQ_GO) ? SQ_IN_W'(quot) : SQ_IN_W'(r2_reg);

    frcb_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (sq_in),
        .ctrl_out (sq_out),
        .value    (sq_value),
        .root     (sq_root)
    );

    frcb_divider #(
        .W (ACC_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (div_in),
        .ctrl_out (div_out),
        .num      (csq_reg),
        .den      (p_reg),
        .quot     (quot)
    );

    // Ring index: round the root of r2 to nearest by testing r2 > k*k + k.
    logic [SQ_IN_W-1:0] k_sq;
    logic [ROOT_W:0]    k_ring;
    logic               k_ok;
    logic               zero_pow;

    assign k_sq     = SQ_IN_W'(sq_root) * SQ_IN_W'(sq_root) + SQ_IN_W'(sq_root);
    assign k_ring   = (ROOT_W+1)'(sq_root) + (ROOT_W+1)'(SQ_IN_W'(r2_reg) > k_sq);
    assign k_ok     = 32'(k_ring) < 32'(NUM_BINS);
    assign zero_pow = (g1_reg == '0) || (g2_reg == '0);

    // The root of floor(c^2 * 2^34 / P) bounds 2m - 1, so the rounded
    // correlation magnitude is half of that root plus one.
    logic [ROOT_W:0] term_mag;
    assign term_mag = ((ROOT_W+1)'(sq_root) + (ROOT_W+1)'(1)) >> 1;

    // Bin memory: sum in the upper bits, count in the lower bits.
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [MEM_W-1:0] mem_wdata, mem_rdata;
    logic [SUM_W-1:0] old_sum;
    logic [CNT_W-1:0] old_cnt;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0] new_cnt;

    assign old_sum  = mem_rdata[MEM_W-1:CNT_W];
    assign old_cnt  = mem_rdata[CNT_W-1:0];
    assign sum_wide = {old_sum[SUM_W-1], old_sum} + (SUM_W+1)'(term_reg);
    assign new_sum  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                    : sum_wide[SUM_W-1:0];
    assign new_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + CNT_W'(1);

    frcb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (bin_reg),
        .rdata (mem_rdata)
    );

    logic is_accum;
    logic slot_free;

    assign is_accum  = opcode_t'(op_reg) == OP_ACCUM;
    assign slot_free = !out_valid_reg || rsp.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (32'(clr_cnt_reg) == 32'(NUM_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            S_IDLE:
                if (req.valid)
                begin
                    state_next = S_CHECK;
                end
            S_CHECK:
                unique case (opcode_t'(op_reg))
                    OP_ACCUM:      state_next = in_range ? S_MAC : S_IDLE;
                    OP_READ:       state_next = S_RD;
                    OP_READ_CLEAR: state_next = S_RD;
                    default:       state_next = S_IDLE;
                endcase
            S_MAC:
                if (step_reg == MAC_LAST)
                begin
                    state_next = S_RSQ_GO;
                end
            S_RSQ_GO:   state_next = S_RSQ_WAIT;
            S_RSQ_WAIT:
                if (sq_out.done)
                begin
                    state_next = S_RADJ;
                end
            S_RADJ:
                priority if (!k_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (zero_pow)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DIV_GO;
                end
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
                if (div_out.done)
                begin
                    state_next = S_QSQ_GO;
                end
            S_QSQ_GO:   state_next = S_QSQ_WAIT;
            S_QSQ_WAIT:
                if (sq_out.done)
                begin
                    state_next = S_TERM;
                end
            S_TERM:     state_next = S_RD;
            S_RD:
                if (is_accum || slot_free)
                begin
                    state_next = S_WR;
                end
            S_WR:       state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req.ready    = state_reg == S_IDLE;
        sq_in.start  = (state_reg == S_RSQ_GO) || (state_reg == S_QSQ_GO);
        sq_in.done   = 1'b0;
        div_in.start = state_reg == S_DIV_GO;
        div_in.done  = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = bin_reg;
        mem_wdata    = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[AW-1:0];
            end
            S_WR:
            begin
                if (is_accum)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {new_sum, new_cnt};
                end
                else
                begin
                    mem_we = bin_ok_reg && (opcode_t'(op_reg) == OP_READ_CLEAR);
                end
            end
            default: begin end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: begin end
                endcase
            end
            if (state_reg == S_CHECK)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_MAC)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if ((state_reg == S_WR) && !is_accum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= req.opcode;
            row_reg    <= req.row;
            col_reg    <= req.col;
            bin_in_reg <= req.bin_index;
            f1r_reg    <= req.first_real;
            f1i_reg    <= req.first_imag;
            f2r_reg    <= req.second_real;
            f2i_reg    <= req.second_imag;
        end
        if (state_reg == S_CHECK)
        begin
            m1r_reg    <= m1r;
            m1i_reg    <= m1i;
            m2r_reg    <= m2r;
            m2i_reg    <= m2i;
            n1r_reg    <= f1r_reg[SB-1];
            n1i_reg    <= f1i_reg[SB-1];
            n2r_reg    <= f2r_reg[SB-1];
            n2i_reg    <= f2i_reg[SB-1];
            dxm_reg    <= MW'(dx_abs);
            dym_reg    <= MW'(dy_abs);
            bin_reg    <= AW'(bin_in_reg);
            bin_ok_reg <= 32'(bin_in_reg) < 32'(NUM_BINS);
        end
        if (state_reg == S_MAC)
        begin
            acc_reg <= acc_sum;
            unique case (store)
                ST_R2:  r2_reg  <= R2_W'(acc_sum);
                ST_G1:  g1_reg  <= G_W'(acc_sum);
                ST_G2:  g2_reg  <= G_W'(acc_sum);
                ST_PR:  pr_reg  <= G_W'(acc_sum);
                ST_PI:  pi_reg  <= G_W'(acc_sum);
                ST_CM:
                begin
                    cmag_reg <= cm;
                    cneg_reg <= cm_neg;
                end
                ST_CSQ: csq_reg <= acc_sum;
                ST_P:   p_reg   <= acc_sum;
                default: begin end
            endcase
        end
        if (state_reg == S_RADJ)
        begin
            bin_reg  <= AW'(k_ring);
            term_reg <= '0;
        end
        if (state_reg == S_TERM)
        begin
            term_reg <= cneg_reg ? -$signed(TERM_W'(term_mag)) : $signed(TERM_W'(term_mag));
        end
        if ((state_reg == S_WR) && !is_accum)
        begin
            out_bin_reg <= bin_in_reg;
            out_sum_reg <= bin_ok_reg ? old_sum : '0;
            out_cnt_reg <= bin_ok_reg ? old_cnt : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_bin   = out_bin_reg;
    assign rsp.ring_sum   = $signed(out_sum_reg);
    assign rsp.ring_count = out_cnt_reg;
endmodule

// ===== src/frcb_checker.sv =====
module frcb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [frcb_pkg::BIN_W-1:0]    rsp_read_bin,
    input logic signed [frcb_pkg::SUM_W-1:0] rsp_ring_sum,
    input logic [frcb_pkg::CNT_W-1:0]    rsp_ring_count
);
    import frcb_pkg::*;

    logic signed [SUM_W+1:0] bound;
    assign bound = $signed({3'b000, rsp_ring_count, 16'b0});

    // Only one request is in flight: acceptance closes the input.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_ring_sum) && $stable(rsp_read_bin)))
        else $error("stalled result changed");

    // Each term lies in [-1, 1] in Q1.16, and saturation keeps it so.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((SUM_W+2)'(rsp_ring_sum) <= bound &&
                       (SUM_W+2)'(rsp_ring_sum) >= -bound))
        else $error("bin sum exceeds its count");

    a_empty_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_ring_count == '0)) |-> (rsp_ring_sum == '0))
        else $error("empty bin with nonzero sum");

    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !req_ready)
        else $error("request taken during clearing pass");
endmodule

bind fourier_ring_correlation_binner_unit frcb_checker u_frcb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_bin   (rsp.read_bin),
    .rsp_ring_sum   (rsp.ring_sum),
    .rsp_ring_count (rsp.ring_count)
);

// ===== bench/testbench.sv =====
module testbench;
    import frcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS       = 512;
    localparam int SIZE_LIMIT = 512;
    localparam int SBITS      = 24;

    // Wait after the last report, so that any read or accumulate still in flight is done.
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [BIN_W-1:0]        bin;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } ring_report_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [DIM_W-1:0] cfg_data;

    frcb_req_if #(.SAMPLE_BITS(SBITS)) req_ch ();
    frcb_rsp_if rsp_ch ();

    fourier_ring_correlation_binner_unit #(
        .MAX_SIZE    (SIZE_LIMIT),
        .NUM_BINS    (BINS),
        .SAMPLE_BITS (SBITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the bin memories and the size registers.
    longint ring_sum_model[BINS];
    int     ring_count_model[BINS];
    int     model_width;
    int     model_height;

    ring_report_t pending_reports[$];

    int  mismatches;
    int  reports_checked;
    int  requests_sent;
    int  accum_sent;
    int  read_sent;
    int  stall_left;
    bit  calm;  // when set, neither side idles

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d reports still pending", pending_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Rounded magnitude of 65536*c/sqrt(g1*g2), found by bisection on the
    // exact comparison (2*65536*c)^2 >= (2m-1)^2 * g1*g2.
    function automatic int unsigned rounded_corr(logic [63:0] c, logic [63:0] g1,
                                                 logic [63:0] g2);
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [191:0] power;
        logic [191:0] odd;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        lhs   = 192'(c) * 192'd131072;
        lhs   = lhs * lhs;
        power = 192'(g1) * 192'(g2);
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 192'(2 * longint'(mid) - 1);
            rhs = power * odd * odd;
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Signed Q1.16 correlation of one pixel pair; zero when either power is zero.
    // Magnitudes are taken in 64 bits so the most negative sample stays positive.
    function automatic longint pair_correlation(logic signed [SBITS-1:0] ar,
                                                logic signed [SBITS-1:0] ai,
                                                logic signed [SBITS-1:0] br,
                                                logic signed [SBITS-1:0] bi);
        logic [63:0] m1r, m1i, m2r, m2i;
        logic [63:0] g1, g2, pr, pim, cmag;
        bit          sr, si, cneg;
        longint      term;
        m1r = ar[SBITS-1] ? (64'd0 - 64'(ar)) : 64'(ar);
        m1i = ai[SBITS-1] ? (64'd0 - 64'(ai)) : 64'(ai);
        m2r = br[SBITS-1] ? (64'd0 - 64'(br)) : 64'(br);
        m2i = bi[SBITS-1] ? (64'd0 - 64'(bi)) : 64'(bi);
        g1 = m1r * m1r + m1i * m1i;
        g2 = m2r * m2r + m2i * m2i;
        if (g1 == 0 || g2 == 0)
            return 0;
        pr  = m1r * m2r;
        pim = m1i * m2i;
        sr  = ar[SBITS-1] ^ br[SBITS-1];
        si  = ai[SBITS-1] ^ bi[SBITS-1];
        if (sr == si)
        begin
            cmag = pr + pim;
            cneg = sr;
        end
        else if (pr >= pim)
        begin
            cmag = pr - pim;
            cneg = sr;
        end
        else
        begin
            cmag = pim - pr;
            cneg = si;
        end
        term = longint'(rounded_corr(cmag, g1, g2));
        return cneg ? -term : term;
    endfunction

    // Updates the bin memories for one accepted request and queues the
    // report that a read or read-and-clear must return.
    task automatic predict_request(opcode_t op, int row, int col, int bin,
                                   logic signed [SBITS-1:0] ar, logic signed [SBITS-1:0] ai,
                                   logic signed [SBITS-1:0] br, logic signed [SBITS-1:0] bi);
        int           w;
        int           h;
        int           dx;
        int           dy;
        int           r2;
        int           k;
        longint       acc;
        ring_report_t rep;
        w = (model_width > SIZE_LIMIT) ? SIZE_LIMIT : model_width;
        h = (model_height > SIZE_LIMIT) ? SIZE_LIMIT : model_height;
        case (op)
            OP_ACCUM:
            begin
                if (row < h && col < w)
                begin
                    dx = col - w / 2;
                    dy = row - h / 2;
                    r2 = dx * dx + dy * dy;
                    k  = 0;
                    while ((k + 1) * (k + 1) <= r2)
                        k++;
                    if (r2 > k * k + k)
                        k++;
                    if (k < BINS)
                    begin
                        acc = ring_sum_model[k] + pair_correlation(ar, ai, br, bi);
                        if (acc > (64'sd1 <<< 35) - 1)
                            acc = (64'sd1 <<< 35) - 1;
                        if (acc < -(64'sd1 <<< 35))
                            acc = -(64'sd1 <<< 35);
                        ring_sum_model[k] = acc;
                        if (ring_count_model[k] < int'(COUNT_MAX))
                            ring_count_model[k]++;
                    end
                end
            end
            OP_READ, OP_READ_CLEAR:
            begin
                rep.bin   = BIN_W'(bin);
                rep.sum   = '0;
                rep.count = '0;
                if (bin < BINS)
                begin
                    rep.sum   = SUM_W'(ring_sum_model[bin]);
                    rep.count = CNT_W'(ring_count_model[bin]);
                    if (op == OP_READ_CLEAR)
                    begin
                        ring_sum_model[bin]   = 0;
                        ring_count_model[bin] = 0;
                    end
                end
                pending_reports.push_back(rep);
            end
            default:
            begin
                // The unused opcode is ignored.
            end
        endcase
    endtask

    // Sends one request: waits a random gap (none when calm is set), presents it, and waits for the
    // handshake. Valid is left high so a back-to-back request needs no drop.
    task automatic send_request(opcode_t op, int row, int col, int bin,
                                logic signed [SBITS-1:0] ar, logic signed [SBITS-1:0] ai,
                                logic signed [SBITS-1:0] br, logic signed [SBITS-1:0] bi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.row         <= POS_W'(row);
        req_ch.col         <= POS_W'(col);
        req_ch.bin_index   <= BIN_W'(bin);
        req_ch.first_real  <= ar;
        req_ch.first_imag  <= ai;
        req_ch.second_real <= br;
        req_ch.second_imag <= bi;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(op, row, col, bin, ar, ai, br, bi);
        requests_sent++;
        if (op == OP_ACCUM)
            accum_sent++;
        else if (op != OP_NONE)
            read_sent++;
    endtask

    task automatic read_ring(opcode_t op, int bin);
        send_request(op, 0, 0, bin, '0, '0, '0, '0);
    endtask

    // Lets every request in flight finish, including accumulates that
    // never produce a report.
    task automatic drain;
        @(posedge clk);
        req_ch.valid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Size registers are only written while the block is idle.
    task automatic set_image_size(int w, int h);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        model_width  = w & 32'h3FF;
        model_height = h & 32'h3FF;
    endtask

    // Samples biased toward the edges of the signed range and toward zero.
    function automatic logic signed [SBITS-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {1'b1, {(SBITS-1){1'b0}}};
            2:       return {1'b0, {(SBITS-1){1'b1}}};
            3, 4:    return SBITS'($urandom_range(0, 31)) - SBITS'(16);
            default: return SBITS'($urandom);
        endcase
    endfunction

    // An upper bound on the rings that the current size can reach, kept within the bin field.
    function automatic int outer_ring();
        int w;
        int h;
        int r;
        w = (model_width > SIZE_LIMIT) ? SIZE_LIMIT : model_width;
        h = (model_height > SIZE_LIMIT) ? SIZE_LIMIT : model_height;
        r = (w + h) / 2 + 2;
        return (r > BINS - 1) ? BINS - 1 : r;
    endfunction

    // Bins hold zero after the clearing pass; read the lowest, the highest and a middle one.
    task automatic test_reset_state;
        read_ring(OP_READ, 0);
        read_ring(OP_READ, BINS - 1);
        read_ring(OP_READ, 255);
    endtask

    // Directed pixel pairs: perfect and inverted correlation, orthogonal
    // samples, zero power on either side, the most negative sample value,
    // sign combinations where the imaginary product dominates, and three of
    // the array corners; then an unused opcode and reads of several rings.
    task automatic test_directed_pairs;
        logic signed [SBITS-1:0] mx;
        logic signed [SBITS-1:0] mn;
        mx = {1'b0, {(SBITS-1){1'b1}}};
        mn = {1'b1, {(SBITS-1){1'b0}}};
        send_request(OP_ACCUM, 256, 256, 0, 24'sd1000, 24'sd500, 24'sd1000, 24'sd500);
        send_request(OP_ACCUM, 256, 256, 0, mx, mx, -mx, -mx);
        send_request(OP_ACCUM, 256, 257, 0, 24'sd7, 24'sd0, 24'sd0, 24'sd9);
        send_request(OP_ACCUM, 257, 257, 0, 24'sd0, 24'sd0, 24'sd3, 24'sd4);
        send_request(OP_ACCUM, 257, 257, 0, 24'sd5, 24'sd1, 24'sd0, 24'sd0);
        send_request(OP_ACCUM, 255, 256, 0, mn, mn, mn, mn);
        send_request(OP_ACCUM, 255, 256, 0, mn, mx, mx, mn);
        send_request(OP_ACCUM, 256, 258, 0, 24'sd3, -24'sd900, -24'sd2, -24'sd800);
        send_request(OP_ACCUM, 256, 258, 0, -24'sd3, 24'sd900, 24'sd2, 24'sd800);
        send_request(OP_ACCUM, 0, 0, 0, 24'sd1, 24'sd1, 24'sd1, -24'sd1);
        send_request(OP_ACCUM, 511, 511, 0, mx, 24'sd1, mn, -24'sd1);
        send_request(OP_ACCUM, 0, 511, 0, 24'sd123, 24'sd456, 24'sd789, 24'sd12);
        send_request(OP_NONE, 256, 256, 0, mx, mx, mx, mx);
        read_ring(OP_READ, 0);
        read_ring(OP_READ_CLEAR, 1);
        read_ring(OP_READ, 1);
        read_ring(OP_READ_CLEAR, 2);
        read_ring(OP_READ_CLEAR, 0);
        read_ring(OP_READ, 363);
        read_ring(OP_READ, 361);
        read_ring(OP_READ, 0);
    endtask

    // Random traffic: mostly accumulates into reachable rings with some
    // positions beyond the configured size, interleaved with reads.
    task automatic test_random_traffic(int count);
        int      sel;
        int      rows;
        int      cols;
        opcode_t op;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            sel  = $urandom_range(0, 99);
            rows = (model_height > SIZE_LIMIT) ? SIZE_LIMIT : model_height;
            cols = (model_width > SIZE_LIMIT) ? SIZE_LIMIT : model_width;
            if (sel < 68)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(OP_ACCUM, $urandom_range(0, 511), $urandom_range(0, 511), 0,
                                 draw_sample(), draw_sample(), draw_sample(), draw_sample());
                else
                    send_request(OP_ACCUM, $urandom_range(0, rows - 1),
                                 $urandom_range(0, cols - 1), $urandom_range(0, 511),
                                 draw_sample(), draw_sample(), draw_sample(), draw_sample());
            end
            else if (sel < 97)
            begin
                op = (sel < 84) ? OP_READ : OP_READ_CLEAR;
                if ($urandom_range(0, 7) == 0)
                    read_ring(op, $urandom_range(0, BINS - 1));
                else
                    read_ring(op, $urandom_range(0, outer_ring()));
            end
            else
                send_request(OP_NONE, $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 511), draw_sample(), draw_sample(),
                             draw_sample(), draw_sample());
        end
        calm = 1'b0;
    endtask

    // Response side: random stalls after each report, and the check of each
    // report against the oldest prediction.
    always @(posedge clk)
    begin
        ring_report_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t unexpected report: bin %0d sum %0d count %0d", $realtime,
                             rsp_ch.read_bin, rsp_ch.ring_sum, rsp_ch.ring_count);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (rsp_ch.read_bin !== want.bin || rsp_ch.ring_sum !== want.sum
                    || rsp_ch.ring_count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t report mismatch: expected bin %0d sum %0d count %0d, got bin %0d sum %0d count %0d",
                                 $realtime, want.bin, want.sum, want.count,
                                 rsp_ch.read_bin, rsp_ch.ring_sum, rsp_ch.ring_count);
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 6);
        end
        else if (stall_left > 0)
            stall_left--;
        rsp_ch.ready <= rst_n && (stall_left == 0);
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_IMAGE_WIDTH;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_NONE;
        req_ch.row         = '0;
        req_ch.col         = '0;
        req_ch.bin_index   = '0;
        req_ch.first_real  = '0;
        req_ch.first_imag  = '0;
        req_ch.second_real = '0;
        req_ch.second_imag = '0;
        rsp_ch.ready       = 1'b0;
        mismatches      = 0;
        reports_checked = 0;
        requests_sent   = 0;
        accum_sent      = 0;
        read_sent       = 0;
        stall_left      = 0;
        calm            = 1'b0;
        model_width     = 512;
        model_height    = 512;
        for (int b = 0; b < BINS; b++)
        begin
            ring_sum_model[b]   = 0;
            ring_count_model[b] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_pairs();
        test_random_traffic(280);

        // Smallest array: every pixel sits within ring one of the centre.
        set_image_size(2, 2);
        test_random_traffic(180);

        // An odd and an even side, unequal, with many positions beyond the size.
        set_image_size(37, 300);
        test_random_traffic(220);

        // Values above the maximum act as the maximum.
        set_image_size(1023, 700);
        test_random_traffic(240);

        set_image_size(512, 3);
        test_random_traffic(160);

        drain();
        $display("Sent %0d requests (%0d accumulates, %0d reads) over five image sizes.",
                 requests_sent, accum_sent, read_sent);
        $display("Checked %0d ring reports, %0d mismatches.", reports_checked, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
